// ----- rtl/core/ctc_pkg.sv -----
// Shared types, constants and helper functions of the CTC greedy decoder.
package ctc_pkg;

	localparam int MAX_CLASSES   = 256;
	localparam int MAX_STEPS     = 256;
	localparam int ALPHABET_SIZE = 95;

	localparam int LOGIT_W = 16;
	localparam int CODE_W  = 7;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = $clog2(MAX_STEPS) + 1;
	localparam int POS_W   = $clog2(MAX_CLASSES + 1);
	localparam int CLS_W   = $clog2(MAX_CLASSES);
	localparam int REM_W   = CNT_W + 1;
	localparam int DIV_CW  = $clog2(SUM_W);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// The alphabet runs from '0' to '~', then '!' to '/', then a space.
	localparam int ALPHA_RUN1_LAST = 79;
	localparam int ALPHA_RUN2_LAST = 94;
	localparam int ALPHA_RUN1_BASE = 8'h2F;
	localparam logic [CODE_W-1:0] ALPHA_SPACE = 7'h20;

	// Map a class index from 1 to ALPHABET_SIZE onto its ASCII code.
	function automatic logic [CODE_W-1:0] char_of(input int idx);
		if (idx <= ALPHA_RUN1_LAST) begin
			return CODE_W'(idx + ALPHA_RUN1_BASE);
		end else if (idx <= ALPHA_RUN2_LAST) begin
			return CODE_W'(idx - ALPHA_RUN1_BASE);
		end else begin
			return ALPHA_SPACE;
		end
	endfunction

endpackage

// ----- rtl/core/ctc_in_if.sv -----
// Logit input channel: valid/ready handshake with one class score per beat.
interface ctc_in_if;
	import ctc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [LOGIT_W-1:0] logit;
	logic                      class_end;
	logic                      seq_end;

	modport source (output valid, logit, class_end, seq_end, input ready);
	modport sink   (input valid, logit, class_end, seq_end, output ready);
endinterface

// ----- rtl/core/ctc_out_if.sv -----
// Result output channel: valid/ready handshake with one decoded step per beat.
interface ctc_out_if;
	import ctc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      char_valid;
	logic [CODE_W-1:0]         char_code;
	logic                      seq_done;
	logic signed [LOGIT_W-1:0] avg_score;

	modport source (output valid, char_valid, char_code, seq_done, avg_score, input ready);
	modport sink   (input valid, char_valid, char_code, seq_done, avg_score, output ready);
endinterface

// ----- rtl/core/ctc_greedy_decoder.sv -----
// CTC greedy decoder: streamed argmax per time step, collapse, and mean score.
//
// Logits enter one class per beat, class 0 first, and the block keeps a running
// argmax for the current time step (the first of equal maxima wins). The beat
// that carries class_end produces one result beat: blank and a repeat of the
// previous step's class emit nothing, any other class from 1 to 95 emits its
// character and adds the best logit to a saturating 24-bit score sum. A beat
// without class_end produces no result. Throughput is one logit beat
// per cycle. The exception is the closing beat of a sequence (class_end and
// seq_end together) when at least one character was emitted: the mean score
// is then found by a restoring divider that retires one quotient bit per
// cycle, and the input is not ready until that division has finished. A new
// beat is also held off while the single output register is full and not
// being drained.
module ctc_greedy_decoder (
	input logic        clk,
	input logic        arst_n,
	ctc_in_if.sink     logits,
	ctc_out_if.source  results
);
	import ctc_pkg::*;

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DIV = 1'b1;

	// Sequencer state.
	logic st_q;

	// Per-step argmax state.
	logic signed [LOGIT_W-1:0] best_val_q;
	logic [CLS_W-1:0]          best_cls_q;
	logic [POS_W-1:0]          pos_q;

	// Per-sequence state.
	logic [CLS_W-1:0]          prev_cls_q;
	logic                      prev_vld_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          cnt_q;

	// Output register.
	logic                      out_vld_q;
	logic                      out_cv_q;
	logic [CODE_W-1:0]         out_code_q;
	logic                      out_done_q;
	logic signed [LOGIT_W-1:0] out_mean_q;

	// Divider registers. The quotient register starts with the dividend
	// magnitude and shifts quotient bits in from the bottom.
	logic [CNT_W-1:0]          div_rem_q;
	logic [SUM_W-1:0]          div_quo_q;
	logic [CNT_W-1:0]          div_den_q;
	logic                      div_neg_q;
	logic [DIV_CW-1:0]         div_cnt_q;
	logic                      hold_cv_q;
	logic [CODE_W-1:0]         hold_code_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      pos_in_range;
	logic signed [LOGIT_W-1:0] nxt_val;
	logic [CLS_W-1:0]          nxt_cls;
	logic                      emit;
	logic signed [SUM_W:0]     sum_wide;
	logic signed [SUM_W-1:0]   sum_sat;
	logic signed [SUM_W-1:0]   sum_nxt;
	logic [CNT_W-1:0]          cnt_nxt;
	logic [CODE_W-1:0]         code_nxt;
	logic [SUM_W-1:0]          mag;
	logic [REM_W-1:0]          rem_sh;
	logic                      quo_bit;
	logic [REM_W-1:0]          rem_diff;
	logic [CNT_W-1:0]          rem_new;
	logic [SUM_W-1:0]          quo_new;
	logic [SUM_W-1:0]          quo_neg;
	logic signed [LOGIT_W-1:0] mean_nxt;
	logic                      div_last;
	logic                      step_out;
	logic                      seq_div;

	assign out_free     = !out_vld_q || results.ready;
	assign logits.ready = (st_q == ST_RUN) && out_free;
	assign in_acc       = logits.valid && logits.ready;

	// Running argmax. The first class of a step always loads; classes past
	// MAX_CLASSES are ignored and the position counter parks there.
	assign pos_in_range = pos_q < POS_W'(MAX_CLASSES);

	always_comb begin
		nxt_val = best_val_q;
		nxt_cls = best_cls_q;
		if (pos_q == '0) begin
			nxt_val = logits.logit;
			nxt_cls = '0;
		end else if (pos_in_range && (logits.logit > best_val_q)) begin
			nxt_val = logits.logit;
			nxt_cls = pos_q[CLS_W-1:0];
		end
	end

	// Collapse: drop blank, drop a repeat, and drop a class past the alphabet.
	assign emit = (nxt_cls != '0) && !(prev_vld_q && (prev_cls_q == nxt_cls))
		&& (int'(nxt_cls) <= ALPHABET_SIZE);

	// Score accumulation saturates at the 24-bit signed limits.
	assign sum_wide = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W + 1)'(nxt_val);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
				: {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	assign sum_nxt  = emit ? sum_sat : sum_q;
	assign cnt_nxt  = (emit && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
	assign code_nxt = emit ? char_of(int'(nxt_cls)) : '0;
	assign mag      = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

	// One restoring division step per cycle.
	assign rem_sh   = {div_rem_q, div_quo_q[SUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, div_den_q};
	assign quo_bit  = rem_sh >= {1'b0, div_den_q};
	assign rem_new  = quo_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
	assign quo_new  = {div_quo_q[SUM_W-2:0], quo_bit};
	assign quo_neg  = -quo_new;
	assign div_last = (st_q == ST_DIV) && (div_cnt_q == '0);

	// The quotient is truncated toward zero, then clamped to 16 bits.
	always_comb begin
		if (div_neg_q) begin
			if (quo_new > SUM_W'(2 ** (LOGIT_W - 1))) begin
				mean_nxt = {1'b1, {(LOGIT_W - 1){1'b0}}};
			end else begin
				mean_nxt = quo_neg[LOGIT_W-1:0];
			end
		end else begin
			if (quo_new > SUM_W'(2 ** (LOGIT_W - 1) - 1)) begin
				mean_nxt = {1'b0, {(LOGIT_W - 1){1'b1}}};
			end else begin
				mean_nxt = quo_new[LOGIT_W-1:0];
			end
		end
	end

	// A step end goes straight to the output unless it needs the divider.
	assign seq_div  = in_acc && logits.class_end && logits.seq_end && (cnt_nxt != '0);
	assign step_out = in_acc && logits.class_end && !seq_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_RUN;
			best_val_q <= '0;
			best_cls_q <= '0;
			pos_q      <= '0;
			prev_cls_q <= '0;
			prev_vld_q <= 1'b0;
			sum_q      <= '0;
			cnt_q      <= '0;
			out_vld_q  <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			case (st_q)
				ST_RUN: begin
					if (seq_div) begin
						st_q      <= ST_DIV;
						div_cnt_q <= DIV_CW'(SUM_W - 1);
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						st_q <= ST_RUN;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				default: begin
					st_q <= ST_RUN;
				end
			endcase

			if (in_acc) begin
				if (!logits.class_end) begin
					best_val_q <= nxt_val;
					best_cls_q <= nxt_cls;
					if (pos_in_range) begin
						pos_q <= pos_q + 1'b1;
					end
				end else begin
					best_val_q <= '0;
					best_cls_q <= '0;
					pos_q      <= '0;
					if (logits.seq_end) begin
						prev_cls_q <= '0;
						prev_vld_q <= 1'b0;
						sum_q      <= '0;
						cnt_q      <= '0;
					end else begin
						prev_cls_q <= nxt_cls;
						prev_vld_q <= 1'b1;
						sum_q      <= sum_nxt;
						cnt_q      <= cnt_nxt;
					end
				end
			end

			if (step_out || div_last) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (seq_div) begin
			div_rem_q   <= '0;
			div_quo_q   <= mag;
			div_den_q   <= cnt_nxt;
			div_neg_q   <= sum_nxt[SUM_W-1];
			hold_cv_q   <= emit;
			hold_code_q <= code_nxt;
		end else if (st_q == ST_DIV) begin
			div_rem_q <= rem_new;
			div_quo_q <= quo_new;
		end

		if (step_out) begin
			out_cv_q   <= emit;
			out_code_q <= code_nxt;
			out_done_q <= logits.seq_end;
			out_mean_q <= '0;
		end else if (div_last) begin
			out_cv_q   <= hold_cv_q;
			out_code_q <= hold_code_q;
			out_done_q <= 1'b1;
			out_mean_q <= mean_nxt;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.char_valid = out_cv_q;
	assign results.char_code  = out_code_q;
	assign results.seq_done   = out_done_q;
	assign results.avg_score  = out_mean_q;

	// The input stays closed for the whole division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> !logits.ready)
		else $error("input ready while the divider is busy");

	// The last division step delivers a closing result.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_last |=> (results.valid && results.seq_done))
		else $error("division finished without a closing result");

	// A result that does not close a sequence reports a zero mean.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.seq_done) |-> (results.avg_score == '0))
		else $error("nonzero mean on a step result");

	// No character code without an emitted character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.char_valid) |-> (results.char_code == '0))
		else $error("character code without an emitted character");

endmodule
